### src/ple_pkg.sv
// Shared types and codes for the positional list engine.
// Used by ple_cell, ple_ctrl and positional_list_engine; depends on nothing.
package ple_pkg;

    typedef enum logic [2:0] {
        OP_GET     = 3'd0,
        OP_LOCATE  = 3'd1,
        OP_INSERT  = 3'd2,
        OP_DELETE  = 3'd3,
        OP_UPDATE  = 3'd4,
        OP_REVERSE = 3'd5,
        OP_LENGTH  = 3'd6,
        OP_CLEAR   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LEFT  = 2'd1,
        CELL_FROM_RIGHT = 2'd2
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t ring_mode;
        cell_mode_t stack_mode;
    } cell_ctl_t;

endpackage

### src/ple_cell.sv
// One storage cell of the element chain: holds a value or takes a neighbor's.
// Depends on ple_pkg for the cell mode codes.
module ple_cell #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                   clk,
    input  ple_pkg::cell_mode_t    mode,
    input  logic [DATA_WIDTH-1:0]  left_in,
    input  logic [DATA_WIDTH-1:0]  right_in,
    output logic [DATA_WIDTH-1:0]  data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        case (mode)
            ple_pkg::CELL_FROM_LEFT:  data_next = left_in;
            ple_pkg::CELL_FROM_RIGHT: data_next = right_in;
            default:                  data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### src/ple_ctrl.sv
// Sequencer of the positional list engine: request decode, rotation step
// counter, element count, feed of the ring tail and result registers.
// Depends on ple_pkg.
module ple_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2:0]             op,
    input  logic [4:0]             position,
    input  logic [15:0]            value,
    input  logic [DATA_WIDTH-1:0]  head,
    input  logic [DATA_WIDTH-1:0]  next_elem,
    input  logic [DATA_WIDTH-1:0]  stack_top,
    output logic [DATA_WIDTH-1:0]  tail,
    output ple_pkg::cell_ctl_t     cell_ctl,
    output logic                   busy,
    output logic                   done,
    output logic [15:0]            result_value,
    output logic [4:0]             found_position,
    output logic [4:0]             count,
    output logic [1:0]             status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);
    localparam int XW = ((CW > 5) ? CW : 5) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROTATE,
        S_POP
    } state_t;

    state_t                 state_reg;
    logic [SW-1:0]          step_reg;
    logic [CW-1:0]          count_reg;
    ple_pkg::op_t           op_reg;
    logic [XW-1:0]          pidx_reg;
    logic [DATA_WIDTH-1:0]  val_reg;
    logic [DATA_WIDTH-1:0]  carry_reg;
    logic [DATA_WIDTH-1:0]  rval_reg;
    logic [4:0]             fpos_reg;
    ple_pkg::status_t       status_reg;
    logic                   done_reg;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] step_x;
    logic          pos_in_list;
    logic          pos_ins_ok;
    logic          full;
    logic          last_step;
    logic          in_list;
    logic          at_pos;
    logic          past_pos;

    assign pos_x       = XW'(position);
    assign cnt_x       = XW'(count_reg);
    assign step_x      = XW'(step_reg);
    assign pos_in_list = (position != 5'd0) && (pos_x <= cnt_x);
    assign pos_ins_ok  = (position != 5'd0) && (pos_x <= cnt_x + XW'(1));
    assign full        = (count_reg == CW'(DEPTH));
    assign last_step   = (step_reg == SW'(DEPTH - 1));
    assign in_list     = (step_x < cnt_x);
    assign at_pos      = (step_x == pidx_reg);
    assign past_pos    = (step_x > pidx_reg);

    // Tail feed: the head leaves the ring each step, the tail takes the
    // element that belongs at the step's index once the ring has come round.
    always_comb
    begin
        tail                = head;
        cell_ctl.ring_mode  = ple_pkg::CELL_HOLD;
        cell_ctl.stack_mode = ple_pkg::CELL_HOLD;
        if (state_reg == S_ROTATE)
        begin
            cell_ctl.ring_mode = ple_pkg::CELL_FROM_RIGHT;
            case (op_reg)
                ple_pkg::OP_UPDATE:
                begin
                    if (at_pos)
                        tail = val_reg;
                end
                ple_pkg::OP_INSERT:
                begin
                    if (at_pos)
                        tail = val_reg;
                    else if (past_pos)
                        tail = carry_reg;
                end
                ple_pkg::OP_DELETE:
                begin
                    // skip the removed element: take the one behind the head
                    if (at_pos || past_pos)
                        tail = next_elem;
                end
                ple_pkg::OP_REVERSE:
                begin
                    if (in_list)
                        cell_ctl.stack_mode = ple_pkg::CELL_FROM_LEFT;
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_POP)
        begin
            cell_ctl.ring_mode = ple_pkg::CELL_FROM_RIGHT;
            if (in_list)
            begin
                tail                = stack_top;
                cell_ctl.stack_mode = ple_pkg::CELL_FROM_RIGHT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            count_reg  <= '0;
            op_reg     <= ple_pkg::OP_GET;
            status_reg <= ple_pkg::ST_OK;
            rval_reg   <= '0;
            fpos_reg   <= '0;
            done_reg   <= 1'b0;
            pidx_reg   <= '0;
            val_reg    <= '0;
            carry_reg  <= '0;
        end
        else
        begin
            done_reg  <= 1'b0;
            carry_reg <= head;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg     <= ple_pkg::op_t'(op);
                        pidx_reg   <= pos_x - XW'(1);
                        val_reg    <= DATA_WIDTH'(value);
                        step_reg   <= '0;
                        rval_reg   <= '0;
                        fpos_reg   <= '0;
                        status_reg <= ple_pkg::ST_OK;
                        unique case (ple_pkg::op_t'(op))
                            ple_pkg::OP_GET,
                            ple_pkg::OP_DELETE,
                            ple_pkg::OP_UPDATE:
                            begin
                                if (pos_in_list)
                                    state_reg <= S_ROTATE;
                                else
                                begin
                                    status_reg <= ple_pkg::ST_BADPOS;
                                    done_reg   <= 1'b1;
                                end
                            end
                            ple_pkg::OP_LOCATE:
                            begin
                                status_reg <= ple_pkg::ST_NOTFOUND;
                                if (count_reg != '0)
                                    state_reg <= S_ROTATE;
                                else
                                    done_reg <= 1'b1;
                            end
                            ple_pkg::OP_INSERT:
                            begin
                                if (!pos_ins_ok)
                                begin
                                    status_reg <= ple_pkg::ST_BADPOS;
                                    done_reg   <= 1'b1;
                                end
                                else if (full)
                                begin
                                    status_reg <= ple_pkg::ST_FULL;
                                    done_reg   <= 1'b1;
                                end
                                else
                                    state_reg <= S_ROTATE;
                            end
                            ple_pkg::OP_REVERSE:
                            begin
                                if (count_reg > CW'(1))
                                    state_reg <= S_ROTATE;
                                else
                                    done_reg <= 1'b1;
                            end
                            ple_pkg::OP_CLEAR:
                            begin
                                count_reg <= '0;
                                done_reg  <= 1'b1;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_ROTATE:
                begin
                    step_reg <= step_reg + SW'(1);
                    if ((op_reg == ple_pkg::OP_GET || op_reg == ple_pkg::OP_DELETE) && at_pos)
                        rval_reg <= head;
                    if (op_reg == ple_pkg::OP_LOCATE && in_list && head == val_reg
                        && status_reg == ple_pkg::ST_NOTFOUND)
                    begin
                        status_reg <= ple_pkg::ST_OK;
                        fpos_reg   <= 5'(step_x + XW'(1));
                    end
                    if (last_step)
                    begin
                        step_reg <= '0;
                        if (op_reg == ple_pkg::OP_REVERSE)
                            state_reg <= S_POP;
                        else
                        begin
                            state_reg <= S_IDLE;
                            done_reg  <= 1'b1;
                            if (op_reg == ple_pkg::OP_INSERT)
                                count_reg <= count_reg + CW'(1);
                            else if (op_reg == ple_pkg::OP_DELETE)
                                count_reg <= count_reg - CW'(1);
                        end
                    end
                end
                S_POP:
                begin
                    step_reg <= step_reg + SW'(1);
                    if (last_step)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign result_value   = 16'(rval_reg);
    assign found_position = fpos_reg;
    assign count          = 5'(count_reg);
    assign status         = status_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe while sequencer still active");

    a_length_fast: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op == ple_pkg::OP_LENGTH |=> done_reg)
        else $error("length request not answered in one cycle");

    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> step_reg == '0)
        else $error("step counter not parked while idle");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && op_reg == ple_pkg::OP_INSERT && status_reg == ple_pkg::ST_OK
        |-> count_reg == CW'($past(count_reg) + CW'(1)))
        else $error("successful insert did not grow the list");
`endif

endmodule

### src/positional_list_engine.sv
// Top level of the positional list engine: ring of element cells, stack
// of cells for reversal, and the sequencer. Depends on ple_pkg, ple_cell
// and ple_ctrl.
//
// Usage: drive op, position and value and raise start; the request
// transfers at a rising edge with start high and busy low. Exactly one
// result follows, shown for one cycle with done high on result_value,
// found_position, count and status; the receiver cannot stall it.
// Length, clear and requests rejected up front (bad position, full list,
// locate on an empty list, reverse of fewer than two elements) answer in
// the cycle after the transfer, with busy staying low.
// Get, locate, update, insert and delete rotate the ring of DEPTH cells
// one full turn, one element per cycle; done comes at the end of the turn
// and a new request can transfer in the cycle of done.
// Reverse makes two turns, one pushing onto the cell stack and one
// popping back, and done comes at the end of the second turn.
// Busy is high throughout each turn.
// Reset empties the list (count zero); stored values need no reset.
module positional_list_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [4:0]  position,
    input  logic [15:0] value,
    output logic        done,
    output logic [15:0] result_value,
    output logic [4:0]  found_position,
    output logic [4:0]  count,
    output logic [1:0]  status
);

    logic [DATA_WIDTH-1:0] ring_q  [DEPTH];
    logic [DATA_WIDTH-1:0] stack_q [DEPTH];
    logic [DATA_WIDTH-1:0] tail;
    ple_pkg::cell_ctl_t    cell_ctl;

    // Ring: cell k takes cell k+1 each step, the last cell takes the tail feed.
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_ring
        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk      (clk),
            .mode     (cell_ctl.ring_mode),
            .left_in  (ring_q[(k + DEPTH - 1) % DEPTH]),
            .right_in ((k == DEPTH - 1) ? tail : ring_q[(k + 1) % DEPTH]),
            .data     (ring_q[k])
        );
    end

    // Stack: top at cell 0; push takes from the left, pop from the right.
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_stack
        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk      (clk),
            .mode     (cell_ctl.stack_mode),
            .left_in  ((k == 0) ? ring_q[0] : stack_q[(k + DEPTH - 1) % DEPTH]),
            .right_in ((k == DEPTH - 1) ? stack_q[k] : stack_q[(k + 1) % DEPTH]),
            .data     (stack_q[k])
        );
    end

    ple_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .op             (op),
        .position       (position),
        .value          (value),
        .head           (ring_q[0]),
        .next_elem      (ring_q[1]),
        .stack_top      (stack_q[0]),
        .tail           (tail),
        .cell_ctl       (cell_ctl),
        .busy           (busy),
        .done           (done),
        .result_value   (result_value),
        .found_position (found_position),
        .count          (count),
        .status         (status)
    );

endmodule
